// ----- rtl/core/wmkd_pkg.sv -----
// Package for the windowed majority key debounce.
// Holds key counts, register codes, reset constants and the counter control struct.
// No dependencies.
package wmkd_pkg;

  localparam int NUM_KEYS = 8;
  localparam int PIN_KEYS = 2;
  localparam int CNT_W    = 8;
  localparam int SEEN_W   = CNT_W + 1;
  localparam int CODE_W   = 3;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [CNT_W-1:0]  WINDOW_RESET  = 8'd20;
  localparam logic [CODE_W-1:0] NO_LADDER_KEY = 3'd7;
  localparam logic [CODE_W-1:0] LADDER_MAX    = 3'd5;

  // word select bit of paddr: register 0 is window_length
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic sample;
    logic pressed;
    logic clear;
  } key_ctl_t;

endpackage

// ----- rtl/core/wmkd_if.sv -----
// Valid/ready channel interfaces for the key debounce sample and result beats.
// Depends on wmkd_pkg for field widths.
interface wmkd_sample_if
  import wmkd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              tick;
  logic              pin_a;
  logic              pin_b;
  logic              adc_ready;
  logic [CODE_W-1:0] adc_code;

  modport source (output valid, tick, pin_a, pin_b, adc_ready, adc_code, input ready);
  modport sink   (input valid, tick, pin_a, pin_b, adc_ready, adc_code, output ready);
endinterface

interface wmkd_result_if
  import wmkd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] key_states;
  logic                decided;

  modport source (output valid, key_states, decided, input ready);
  modport sink   (input valid, key_states, decided, output ready);
endinterface

// ----- rtl/core/wmkd_key_cnt.sv -----
// Per-key released/pressed counter pair with majority vote.
// Depends on wmkd_pkg.
module wmkd_key_cnt
  import wmkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  key_ctl_t          ctl,
  output logic [SEEN_W-1:0] seen,
  output logic              vote
);

  logic [CNT_W-1:0] released_cnt;
  logic [CNT_W-1:0] pressed_cnt;
  logic [CNT_W-1:0] released_cnt_next;
  logic [CNT_W-1:0] pressed_cnt_next;

  // counts including the current sample
  always_comb begin
    released_cnt_next = released_cnt;
    pressed_cnt_next  = pressed_cnt;
    if (ctl.sample) begin
      if (ctl.pressed) begin
        pressed_cnt_next = pressed_cnt + CNT_W'(1);
      end else begin
        released_cnt_next = released_cnt + CNT_W'(1);
      end
    end
  end

  assign seen = SEEN_W'(released_cnt_next) + SEEN_W'(pressed_cnt_next);
  assign vote = pressed_cnt_next >= released_cnt_next;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      released_cnt <= '0;
      pressed_cnt  <= '0;
    end else begin
      released_cnt <= released_cnt_next;
      pressed_cnt  <= pressed_cnt_next;
    end
  end

endmodule

// ----- rtl/core/windowed_majority_key_debounce.sv -----
// Windowed majority key debounce, top level: APB register, ladder decode, result register.
// Result is registered after the sample beat; one beat per cycle unless result stalls.
// A sample is taken while the result register is empty or being drained.
// Synchronous reset: counters cleared, states zero, held ADC code no key, window 20.
// Depends on wmkd_pkg, wmkd_if and wmkd_key_cnt.
module windowed_majority_key_debounce
  import wmkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  wmkd_sample_if.sink       sample,
  wmkd_result_if.source     result
);

  logic [CNT_W-1:0]    window_length;
  logic [NUM_KEYS-1:0] debounced;
  logic [CODE_W-1:0]   held_code;
  logic [CODE_W-1:0]   held_code_next;
  logic                accept;
  logic                cfg_wr;
  logic                decide;
  logic [SEEN_W-1:0]   need;
  logic [NUM_KEYS-1:0] key_pressed;
  logic [NUM_KEYS-1:0] votes;
  logic [NUM_KEYS-1:0] key_states_new;
  logic [SEEN_W-1:0]   seen [NUM_KEYS];
  key_ctl_t            ctl  [NUM_KEYS];

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? DATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_wr && paddr[2] == REG_WINDOW_LENGTH) begin
      window_length <= pwdata[CNT_W-1:0];
    end
  end

  // sample side
  assign sample.ready = !result.valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  assign held_code_next = (sample.tick && sample.adc_ready) ? sample.adc_code : held_code;

  always_comb begin
    key_pressed    = '0;
    key_pressed[0] = !sample.pin_a;
    key_pressed[1] = !sample.pin_b;
    for (int k = PIN_KEYS; k < NUM_KEYS; k++) begin
      key_pressed[k] = (held_code_next <= LADDER_MAX) &&
                       (SEEN_W'(held_code_next) + SEEN_W'(PIN_KEYS) == SEEN_W'(k));
    end
  end

  // window of zero behaves as one
  assign need   = (window_length == '0) ? SEEN_W'(1) : SEEN_W'(window_length);
  assign decide = accept && sample.tick && (seen[0] >= need);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    assign ctl[k] = '{sample: accept && sample.tick, pressed: key_pressed[k], clear: decide};
    wmkd_key_cnt u_cnt (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl[k]),
      .seen (seen[k]),
      .vote (votes[k])
    );
  end

  assign key_states_new = decide ? votes : debounced;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_code <= NO_LADDER_KEY;
      debounced <= '0;
    end else if (accept) begin
      held_code <= held_code_next;
      debounced <= key_states_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.key_states <= key_states_new;
      result.decided    <= decide;
    end
  end

  // checks
  a_no_tick_no_decide: assert property (@(posedge clk) disable iff (rst)
    accept && !sample.tick |=> !result.decided)
    else $error("decided set on a beat without tick");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid && result.key_states == debounced)
    else $error("result states differ from debounced states");

  a_keys_aligned: assert property (@(posedge clk) disable iff (rst)
    seen[NUM_KEYS-1] == seen[0])
    else $error("key counters out of step");

  a_window_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && paddr[2] == REG_WINDOW_LENGTH |=> window_length == $past(pwdata[CNT_W-1:0]))
    else $error("window_length write lost");

endmodule

// ----- tb/tb_windowed_majority_key_debounce.sv -----
// Testbench for windowed_majority_key_debounce: directed and random sample beats checked
// against an in-bench vote predictor, window length set over APB between phases.
// Depends on wmkd_pkg, wmkd_if and the debounce RTL.
module tb_windowed_majority_key_debounce;
  import wmkd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [ADDR_W-1:0] ADDR_WINDOW   = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = {~REG_WINDOW_LENGTH, 2'b00};

  typedef struct packed {
    logic [NUM_KEYS-1:0] key_states;
    logic                decided;
  } key_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  wmkd_sample_if smp ();
  wmkd_result_if res ();

  windowed_majority_key_debounce dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (smp),
    .result  (res)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [CNT_W-1:0]    released_cnt [NUM_KEYS];
  logic [CNT_W-1:0]    pressed_cnt  [NUM_KEYS];
  logic [NUM_KEYS-1:0] voted_states;
  logic [CODE_W-1:0]   held_code;
  logic [CNT_W-1:0]    window_len;

  key_result_t expected_states[$];
  key_result_t want;
  int          errors;
  int          beats_sent;
  int          ticks_sent;
  int          decisions_seen;
  int          quiet_cycles;
  bit          idle_en;

  task automatic predict_key_states(input logic tk, input logic pa, input logic pb,
                                    input logic rdy, input logic [CODE_W-1:0] code);
    key_result_t         r;
    int                  seen;
    int                  need;
    int                  k;
    logic                hit;
    logic [NUM_KEYS-1:0] s;
    r.decided = 1'b0;
    if (tk) begin
      if (rdy) held_code = code;
      for (k = 0; k < NUM_KEYS; k++) begin
        if (k == 0) hit = !pa;
        else if (k == 1) hit = !pb;
        else hit = (held_code <= LADDER_MAX) && (int'(held_code) + PIN_KEYS == k);
        if (hit) pressed_cnt[k] = pressed_cnt[k] + 1'b1;
        else released_cnt[k] = released_cnt[k] + 1'b1;
      end
      seen = int'(released_cnt[0]) + int'(pressed_cnt[0]);
      need = (window_len == 0) ? 1 : int'(window_len);
      if (seen >= need) begin
        s = '0;
        for (k = 0; k < NUM_KEYS; k++) begin
          if (pressed_cnt[k] >= released_cnt[k]) s[k] = 1'b1;
          released_cnt[k] = '0;
          pressed_cnt[k]  = '0;
        end
        voted_states = s;
        r.decided = 1'b1;
      end
    end
    r.key_states = voted_states;
    expected_states.push_back(r);
  endtask

  task automatic send_sample(input logic tk, input logic pa, input logic pb,
                             input logic rdy, input logic [CODE_W-1:0] code);
    int gap;
    gap = idle_en ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid     <= 1'b1;
    smp.tick      <= tk;
    smp.pin_a     <= pa;
    smp.pin_b     <= pb;
    smp.adc_ready <= rdy;
    smp.adc_code  <= code;
    do @(posedge clk); while (!smp.ready);
    predict_key_states(tk, pa, pb, rdy, code);
    beats_sent++;
    if (tk) ticks_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    smp.valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    drain_results();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[ADDR_W-1] == REG_WINDOW_LENGTH) window_len = data[CNT_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ignored beats must not latch a new ladder code
  task automatic test_no_tick();
    send_sample(1'b0, 1'b0, 1'b0, 1'b1, 3'd0);
    send_sample(1'b0, 1'b1, 1'b0, 1'b1, 3'd2);
  endtask

  // window 0 acts as 1: every code decoded, then held code reused
  task automatic test_window_zero();
    int c;
    write_reg(ADDR_WINDOW, 32'h0);
    send_sample(1'b1, 1'b0, 1'b1, 1'b0, 3'd0);
    for (c = 0; c < 8; c++) send_sample(1'b1, c[0], c[1], 1'b1, c[CODE_W-1:0]);
    send_sample(1'b1, 1'b1, 1'b1, 1'b1, 3'd3);
    send_sample(1'b1, 1'b0, 1'b0, 1'b0, 3'd0);
  endtask

  // equal counts vote pressed
  task automatic test_tie_vote();
    write_reg(ADDR_WINDOW, 32'h2);
    send_sample(1'b1, 1'b0, 1'b1, 1'b1, 3'd1);
    send_sample(1'b1, 1'b1, 1'b0, 1'b1, 3'd6);
  endtask

  // unmapped write ignored; lowering the window mid-window decides at once
  task automatic test_window_lowered();
    int i;
    write_reg(ADDR_WINDOW, 32'd12);
    for (i = 0; i < 6; i++)
      send_sample(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 7)));
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    send_sample(1'b1, 1'b0, 1'b1, 1'b1, 3'd4);
    write_reg(ADDR_WINDOW, 32'h3);
    send_sample(1'b1, 1'b1, 1'b0, 1'b0, 3'd5);
  endtask

  task automatic test_random_phase(input int win, input int n_beats, input bit idle);
    int          done;
    int          pct_a;
    int          pct_b;
    int          fav_code;
    bit          paused;
    logic        tk;
    logic [31:0] junk;
    junk = $urandom;
    write_reg(ADDR_WINDOW, {junk[DATA_W-1:CNT_W], win[CNT_W-1:0]});
    idle_en  = idle;
    done     = 0;
    paused   = 1'b0;
    pct_a    = 50;
    pct_b    = 50;
    fav_code = 7;
    while (done < n_beats) begin
      if (released_cnt[0] == 0 && pressed_cnt[0] == 0) begin
        pct_a    = $urandom_range(0, 100);
        pct_b    = $urandom_range(0, 100);
        fav_code = $urandom_range(0, 7);
      end
      if (!paused && done == n_beats / 2) begin
        drain_results();
        paused = 1'b1;
      end
      tk = ($urandom_range(0, 9) != 0);
      send_sample(tk,
                  ($urandom_range(0, 99) < pct_a) ? 1'b0 : 1'b1,
                  ($urandom_range(0, 99) < pct_b) ? 1'b0 : 1'b1,
                  1'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0) ? CODE_W'($urandom_range(0, 7))
                                              : CODE_W'(fav_code));
      done++;
    end
  endtask

  // result beat checker
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (res.decided) decisions_seen++;
      if (expected_states.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat key_states=%h decided=%b",
                 $time, res.key_states, res.decided);
      end else begin
        want = expected_states.pop_front();
        if (res.key_states !== want.key_states) begin
          errors++;
          $display("%0t: key_states expected %h actual %h",
                   $time, want.key_states, res.key_states);
        end
        if (res.decided !== want.decided) begin
          errors++;
          $display("%0t: decided expected %b actual %b", $time, want.decided, res.decided);
        end
      end
    end
  end

  // result sink with random stalls while idle_en is set
  initial begin
    int stall;
    res.ready = 1'b0;
    wait (!rst);
    forever begin
      stall = idle_en ? $urandom_range(0, 3) : 0;
      @(negedge clk);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int k;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    smp.valid     = 1'b0;
    smp.tick      = 1'b0;
    smp.pin_a     = 1'b1;
    smp.pin_b     = 1'b1;
    smp.adc_ready = 1'b0;
    smp.adc_code  = '0;
    for (k = 0; k < NUM_KEYS; k++) begin
      released_cnt[k] = '0;
      pressed_cnt[k]  = '0;
    end
    voted_states   = '0;
    held_code      = NO_LADDER_KEY;
    window_len     = WINDOW_RESET;
    errors         = 0;
    beats_sent     = 0;
    ticks_sent     = 0;
    decisions_seen = 0;
    idle_en        = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_no_tick();
    test_window_zero();
    test_tie_vote();
    test_window_lowered();

    test_random_phase(1, 120, 1'b1);
    test_random_phase(2, 120, 1'b1);
    test_random_phase(255, 560, 1'b1);
    test_random_phase(5, 150, 1'b0);
    test_random_phase($urandom_range(3, 40), 150, 1'b1);
    test_random_phase($urandom_range(3, 40), 150, 1'b1);
    test_random_phase($urandom_range(3, 40), 150, 1'b0);
    test_random_phase(int'(WINDOW_RESET), 150, 1'b1);

    drain_results();
    repeat (8) @(posedge clk);
    if (expected_states.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_states.size());
    end
    $display("Sent %0d sample beats (%0d ticks); %0d window decisions observed.",
             beats_sent, ticks_sent, decisions_seen);
    $display("Windows 0, 1, 2, 3, 5, 12, 20, 255 and random, unmapped write, mid-window change.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
